// ----- hw/rtl/uvct_pkg.sv -----
// types and constants shared by the udp connection tracker modules
package uvct_pkg;

  // packet framing
  localparam int unsigned HEADER_BYTES = 4;

  // event kinds
  localparam logic [1:0] KIND_OPEN   = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_ARRIVE = 2'd3;

  // link states
  localparam logic [2:0] ST_DISC       = 3'd0;
  localparam logic [2:0] ST_LISTEN     = 3'd1;
  localparam logic [2:0] ST_CONNECTING = 3'd2;
  localparam logic [2:0] ST_CONNECTED  = 3'd3;
  localparam logic [2:0] ST_FAIL       = 3'd4;

  // link modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SERVER = 2'd1;
  localparam logic [1:0] MODE_CLIENT = 2'd2;

  // link events
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_PROTOCOL_ID  = 3'd0;
  localparam logic [2:0] CFG_TIMEOUT_MS   = 3'd1;
  localparam logic [2:0] CFG_ROLE         = 3'd2;
  localparam logic [2:0] CFG_PEER_ADDRESS = 3'd3;
  localparam logic [2:0] CFG_PEER_PORT    = 3'd4;

  localparam logic [23:0] TIMEOUT_RESET = 24'd10000;
  localparam logic [23:0] QUIET_MAX     = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] elapsed_ms;
    logic [31:0] sender_address;
    logic [15:0] sender_port;
    logic [31:0] header_word;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  link_status;
    logic        accepted;
    logic [15:0] payload_length;
    logic [1:0]  link_event;
  } out_item_t;

  typedef struct packed {
    logic [31:0] protocol_id;
    logic [23:0] timeout_ms;
    logic        role;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  link_state;
    logic [1:0]  link_mode;
    logic [31:0] bound_address;
    logic [15:0] bound_port;
    logic [23:0] quiet_time;
  } conn_t;

endpackage

// ----- hw/rtl/uvct_cfg_regs.sv -----
// configuration register file of the udp connection tracker
module uvct_cfg_regs import uvct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  // write one register per enabled cycle, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_id  <= 32'd0;
      cfg_q.timeout_ms   <= TIMEOUT_RESET;
      cfg_q.role         <= 1'b0;
      cfg_q.peer_address <= 32'd0;
      cfg_q.peer_port    <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROTOCOL_ID:  cfg_q.protocol_id  <= cfg_wdata_i;
        CFG_TIMEOUT_MS:   cfg_q.timeout_ms   <= cfg_wdata_i[23:0];
        CFG_ROLE:         cfg_q.role         <= cfg_wdata_i[0];
        CFG_PEER_ADDRESS: cfg_q.peer_address <= cfg_wdata_i;
        CFG_PEER_PORT:    cfg_q.peer_port    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/uvct_step.sv -----
// next-state and result logic for one event of the udp connection tracker
module uvct_step import uvct_pkg::*; (
  input  in_item_t  item_i,
  input  conn_t     conn_i,
  input  cfg_t      cfg_i,
  output conn_t     conn_o,
  output out_item_t result_o
);

  logic [24:0] quiet_sum;
  logic [23:0] quiet_sat;
  logic        was_up;
  logic        pkt_ok;

  assign quiet_sum = {1'b0, conn_i.quiet_time} + {9'd0, item_i.elapsed_ms};
  assign quiet_sat = quiet_sum[24] ? QUIET_MAX : quiet_sum[23:0];
  assign was_up    = (conn_i.link_state == ST_CONNECTED);
  assign pkt_ok    = (item_i.packet_length > 16'(HEADER_BYTES)) &&
                     (item_i.header_word == cfg_i.protocol_id);

  always_comb begin
    conn_o   = conn_i;
    result_o = '0;
    result_o.link_event = EV_NONE;
    case (item_i.kind)
      // open: clear, then listen or connect by role
      KIND_OPEN: begin
        conn_o.quiet_time    = 24'd0;
        conn_o.bound_address = 32'd0;
        conn_o.bound_port    = 16'd0;
        if (was_up) begin
          result_o.link_event = EV_DOWN;
        end
        if (!cfg_i.role) begin
          conn_o.link_mode  = MODE_SERVER;
          conn_o.link_state = ST_LISTEN;
        end else begin
          conn_o.link_mode     = MODE_CLIENT;
          conn_o.link_state    = ST_CONNECTING;
          conn_o.bound_address = cfg_i.peer_address;
          conn_o.bound_port    = cfg_i.peer_port;
        end
      end
      // close: clear, mode kept
      KIND_CLOSE: begin
        conn_o.link_state    = ST_DISC;
        conn_o.quiet_time    = 24'd0;
        conn_o.bound_address = 32'd0;
        conn_o.bound_port    = 16'd0;
        if (was_up) begin
          result_o.link_event = EV_DOWN;
        end
      end
      // tick: saturating timer and timeout
      KIND_TICK: begin
        conn_o.quiet_time = quiet_sat;
        if (quiet_sat > cfg_i.timeout_ms) begin
          if (conn_i.link_state == ST_CONNECTING || conn_i.link_state == ST_CONNECTED ||
              conn_i.link_state == ST_LISTEN) begin
            conn_o.link_state    = (conn_i.link_state == ST_CONNECTING) ? ST_FAIL : ST_DISC;
            conn_o.quiet_time    = 24'd0;
            conn_o.bound_address = 32'd0;
            conn_o.bound_port    = 16'd0;
            result_o.link_event  = EV_DOWN;
          end
        end
      end
      // arrival: checks, server adoption, client handshake
      KIND_ARRIVE: begin
        if (pkt_ok) begin
          if (conn_i.link_mode == MODE_SERVER && !was_up) begin
            conn_o.link_state    = ST_CONNECTED;
            conn_o.bound_address = item_i.sender_address;
            conn_o.bound_port    = item_i.sender_port;
            result_o.link_event  = EV_UP;
          end
          if (item_i.sender_address == conn_o.bound_address &&
              item_i.sender_port == conn_o.bound_port) begin
            if (conn_i.link_mode == MODE_CLIENT && conn_i.link_state == ST_CONNECTING) begin
              conn_o.link_state   = ST_CONNECTED;
              result_o.link_event = EV_UP;
            end
            conn_o.quiet_time       = 24'd0;
            result_o.accepted       = 1'b1;
            result_o.payload_length = item_i.packet_length - 16'(HEADER_BYTES);
          end
        end
      end
      default: ;
    endcase
    result_o.link_status = conn_o.link_state;
  end

endmodule

// ----- hw/rtl/udp_virtual_connection_tracker.sv -----
// top level of the udp virtual connection tracker
//
// tracks one connection over a datagram link. each input item is one event
// (open, close, tick or packet arrival) and yields exactly one result item
// with the link status after the event, the acceptance flag, the payload
// length and a link event (connect, disconnect or none).
// channels: in_valid_i / in_ready_o / in_item_i for events and
// out_valid_o / out_ready_i / out_item_o for results, both valid and ready.
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 protocol id, 1 timeout, 2 role, 3 peer address, 4 peer port); the user must
// do so only while the block is idle, the block does not enforce it.
// path: an accepted item waits in the input register, which feeds the event logic,
// whose output lands in the result register.
// throughput: one item per cycle while out_ready_i stays high.
// stall: while out_ready_i is low and a result waits, the input register still
// takes one more item, then in_ready_o drops until the result is taken.
// reset: link disconnected, mode none, bound peer 0:0, timer 0, timeout 10000,
// all other registers 0; both pipeline registers empty.
module udp_virtual_connection_tracker import uvct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t res_q;
  logic      res_valid_q;
  conn_t     conn_q;
  conn_t     conn_d;
  out_item_t res_d;
  logic      advance;

  uvct_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  uvct_step u_step (
    .item_i   (item_q),
    .conn_i   (conn_q),
    .cfg_i    (cfg),
    .conn_o   (conn_d),
    .result_o (res_d)
  );

  // an item moves on when the result register is free or being emptied
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  // connection state, updated as each item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q.link_state    <= ST_DISC;
      conn_q.link_mode     <= MODE_NONE;
      conn_q.bound_address <= 32'd0;
      conn_q.bound_port    <= 16'd0;
      conn_q.quiet_time    <= 24'd0;
    end else if (advance) begin
      conn_q <= conn_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule
